>>> sv/lslsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslsm_pkg
// Shared types, constants and helpers of the latency slot load/store memory.
// ----------------------------------------------------------------------------
package lslsm_pkg;

  localparam int SLOTS     = 4;
  localparam int ADDR_BITS = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = 4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_STORE = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_BCAST = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  localparam logic [2:0] SZ_BYTE_S = 3'd0;
  localparam logic [2:0] SZ_BYTE_U = 3'd1;
  localparam logic [2:0] SZ_HALF_S = 3'd2;
  localparam logic [2:0] SZ_HALF_U = 3'd3;
  localparam logic [2:0] SZ_WORD   = 3'd4;

  typedef logic [SLOTS-1:0][3:0] sid_arr_t;

  typedef struct packed {
    logic alloc_load;
    logic alloc_store;
    logic tick;
  } slot_cmd_t;

  typedef struct packed {
    logic                 send;
    logic [4:0]           tag;
    logic [ADDR_BITS-1:0] addr;
    logic [2:0]           size;
    logic [SLOTS-1:0]     done;
  } tick_t;

  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [2:0] num_bytes(input logic [2:0] size);
    logic [2:0] n;
    unique case (size)
      SZ_BYTE_S, SZ_BYTE_U: n = 3'd1;
      SZ_HALF_S, SZ_HALF_U: n = 3'd2;
      SZ_WORD:              n = 3'd4;
      default:              n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] extend(input logic [31:0] raw, input logic [2:0] size);
    logic [31:0] v;
    unique case (size)
      SZ_BYTE_S: v = {{24{raw[7]}}, raw[7:0]};
      SZ_BYTE_U: v = {24'd0, raw[7:0]};
      SZ_HALF_S: v = {{16{raw[15]}}, raw[15:0]};
      SZ_HALF_U: v = {16'd0, raw[15:0]};
      SZ_WORD:   v = raw;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/latency_slot_load_store_memory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// latency_slot_load_store_memory
// Byte memory served through countdown load and store request slots.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// input     start / busy            op, addr, size, rob_id, store_id,
//                                   write_byte, bus_free
// result    strobe_o, one cycle     kind, ok, bcast_rob_id, load_value,
//                                   done_store_id, last
//
// After reset the block clears the byte memory, one address per cycle, and
// holds busy high until the last address is cleared. A request is answered
// in the cycle after it is taken, and the next item may follow at once. A
// byte write does not raise busy. A tick reads a sent load's bytes via the
// single memory read port, broadcasts it, then reports each completed store.
// ----------------------------------------------------------------------------
module latency_slot_load_store_memory
  import lslsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [2:0]  size_i,
  input  wire logic [4:0]  rob_id_i,
  input  wire logic [3:0]  store_id_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic        bus_free_i,
  output logic             strobe_o,
  output logic [1:0]       kind_o,
  output logic             ok_o,
  output logic [4:0]       bcast_rob_id_o,
  output logic [31:0]      load_value_o,
  output logic [3:0]       done_store_id_o,
  output logic             last_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [ADDR_BITS-1:0] clr_q;
  logic [2:0]           cnt_q;
  logic [ADDR_BITS-1:0] base_q;
  logic [2:0]           size_q;
  logic [4:0]           tag_q;
  logic [SLOTS-1:0]     done_q;
  sid_arr_t             sids_q;
  logic [3:0][7:0]      bytes_q;
  logic [3:0][7:0]      bytes_d;

  logic                 accept;
  op_e                  op;
  slot_cmd_t            cmd;
  logic                 load_free;
  logic                 store_free;
  tick_t                tick;
  sid_arr_t             sids;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [7:0]           ram_rdata;
  logic [SLOT_W-1:0]    done_idx;
  logic [SLOTS-1:0]     done_rest;

  assign busy   = state_q != ST_IDLE;
  assign accept = start && !busy;
  assign op     = op_e'(op_i);

  assign cmd.alloc_load  = accept && op == OP_LOAD;
  assign cmd.alloc_store = accept && op == OP_STORE;
  assign cmd.tick        = accept && op == OP_TICK;

  assign ram_we    = state_q == ST_CLEAR || (accept && op == OP_WRITE);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_i[ADDR_BITS-1:0];
  assign ram_wdata = (state_q == ST_CLEAR) ? 8'd0 : write_byte_i;
  assign ram_raddr = base_q + ADDR_BITS'(cnt_q);

  assign done_idx  = first_set(done_q);
  assign done_rest = done_q & ~(SLOTS'(1) << done_idx);

  always_comb begin
    bytes_d = bytes_q;
    if (cnt_q != 3'd0) begin
      bytes_d[cnt_q[1:0] - 2'd1] = ram_rdata;
    end
  end

  lslsm_slots u_slots (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .addr_i       (addr_i[ADDR_BITS-1:0]),
    .size_i       (size_i),
    .rob_id_i     (rob_id_i),
    .store_id_i   (store_id_i),
    .bus_free_i   (bus_free_i),
    .load_free_o  (load_free),
    .store_free_o (store_free),
    .tick_o       (tick),
    .sids_o       (sids)
  );

  lslsm_ram #(
    .AW (ADDR_BITS),
    .DW (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      cnt_q           <= '0;
      base_q          <= '0;
      size_q          <= '0;
      tag_q           <= '0;
      done_q          <= '0;
      sids_q          <= '0;
      bytes_q         <= '0;
      strobe_o        <= 1'b0;
      kind_o          <= KIND_REPLY;
      ok_o            <= 1'b0;
      bcast_rob_id_o  <= '0;
      load_value_o    <= '0;
      done_store_id_o <= '0;
      last_o          <= 1'b0;
    end else begin
      strobe_o        <= 1'b0;
      kind_o          <= KIND_REPLY;
      ok_o            <= 1'b0;
      bcast_rob_id_o  <= '0;
      load_value_o    <= '0;
      done_store_id_o <= '0;
      last_o          <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_BITS'(1);
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_LOAD, OP_STORE: begin
                strobe_o <= 1'b1;
                ok_o     <= (op == OP_LOAD) ? load_free : store_free;
                last_o   <= 1'b1;
              end
              OP_TICK: begin
                done_q <= tick.done;
                sids_q <= sids;
                base_q <= tick.addr;
                size_q <= tick.size;
                tag_q  <= tick.tag;
                cnt_q  <= '0;
                if (tick.send) begin
                  state_q <= ST_READ;
                end else if (|tick.done) begin
                  state_q <= ST_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          bytes_q <= bytes_d;
          if (cnt_q == num_bytes(size_q)) begin
            strobe_o       <= 1'b1;
            kind_o         <= KIND_BCAST;
            bcast_rob_id_o <= tag_q;
            load_value_o   <= extend(bytes_d, size_q);
            last_o         <= ~|done_q;
            cnt_q          <= '0;
            state_q        <= (|done_q) ? ST_DONE : ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DONE: begin
          strobe_o        <= 1'b1;
          kind_o          <= KIND_DONE;
          done_store_id_o <= sids_q[done_idx];
          last_o          <= ~|done_rest;
          done_q          <= done_rest;
          if (~|done_rest) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lslsm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslsm_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lslsm_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/lslsm_slots.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslsm_slots
// Load and store request slots: allocation, countdown and completion on tick.
// ----------------------------------------------------------------------------
module lslsm_slots
  import lslsm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire slot_cmd_t            cmd_i,
  input  wire logic [ADDR_BITS-1:0] addr_i,
  input  wire logic [2:0]           size_i,
  input  wire logic [4:0]           rob_id_i,
  input  wire logic [3:0]           store_id_i,
  input  wire logic                 bus_free_i,
  output logic                      load_free_o,
  output logic                      store_free_o,
  output tick_t                     tick_o,
  output sid_arr_t                  sids_o
);

  logic [SLOTS-1:0]                 load_busy_q;
  logic [SLOTS-1:0][CNT_W-1:0]      load_cnt_q;
  logic [SLOTS-1:0][ADDR_BITS-1:0]  load_addr_q;
  logic [SLOTS-1:0][2:0]            load_size_q;
  logic [SLOTS-1:0][4:0]            load_tag_q;
  logic [SLOTS-1:0]                 store_busy_q;
  logic [SLOTS-1:0][CNT_W-1:0]      store_cnt_q;
  sid_arr_t                         store_tag_q;

  logic [SLOTS-1:0][CNT_W-1:0]      load_cnt_d;
  logic [SLOTS-1:0][CNT_W-1:0]      store_cnt_d;
  logic [SLOTS-1:0]                 load_zero;
  logic [SLOTS-1:0]                 store_done;
  logic [SLOT_W-1:0]                load_free_idx;
  logic [SLOT_W-1:0]                store_free_idx;
  logic [SLOT_W-1:0]                cand_idx;
  logic                             send;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      load_cnt_d[i]  = (load_busy_q[i] && load_cnt_q[i] != '0) ?
                       load_cnt_q[i] - CNT_W'(1) : load_cnt_q[i];
      load_zero[i]   = load_busy_q[i] && load_cnt_d[i] == '0;
      store_cnt_d[i] = store_cnt_q[i] - CNT_W'(1);
      store_done[i]  = store_busy_q[i] && store_cnt_d[i] == '0;
    end
  end

  assign load_free_o    = ~&load_busy_q;
  assign store_free_o   = ~&store_busy_q;
  assign load_free_idx  = first_set(~load_busy_q);
  assign store_free_idx = first_set(~store_busy_q);
  assign cand_idx       = first_set(load_zero);
  assign send           = (|load_zero) && bus_free_i;

  assign tick_o.send = send;
  assign tick_o.tag  = load_tag_q[cand_idx];
  assign tick_o.addr = load_addr_q[cand_idx];
  assign tick_o.size = load_size_q[cand_idx];
  assign tick_o.done = store_done;
  assign sids_o      = store_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_busy_q  <= '0;
      load_cnt_q   <= '0;
      store_busy_q <= '0;
      store_cnt_q  <= '0;
    end else begin
      if (cmd_i.alloc_load && load_free_o) begin
        load_busy_q[load_free_idx] <= 1'b1;
        load_cnt_q[load_free_idx]  <= CNT_W'(SLOTS - 1);
      end
      if (cmd_i.alloc_store && store_free_o) begin
        store_busy_q[store_free_idx] <= 1'b1;
        store_cnt_q[store_free_idx]  <= CNT_W'(SLOTS - 1);
      end
      if (cmd_i.tick) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (load_busy_q[i]) begin
            load_cnt_q[i] <= load_cnt_d[i];
          end
          if (store_busy_q[i]) begin
            store_cnt_q[i] <= store_cnt_d[i];
          end
        end
        store_busy_q <= store_busy_q & ~store_done;
        if (send) begin
          load_busy_q[cand_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_load && load_free_o) begin
      load_addr_q[load_free_idx] <= addr_i;
      load_size_q[load_free_idx] <= size_i;
      load_tag_q[load_free_idx]  <= rob_id_i;
    end
    if (cmd_i.alloc_store && store_free_o) begin
      store_tag_q[store_free_idx] <= store_id_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/lslsm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lslsm_checker
// Port-level checks of result ordering and field usage, bound to the top.
// ----------------------------------------------------------------------------
module lslsm_props
  import lslsm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  op_i,
  input wire logic        strobe_o,
  input wire logic [1:0]  kind_o,
  input wire logic        ok_o,
  input wire logic [4:0]  bcast_rob_id_o,
  input wire logic [31:0] load_value_o,
  input wire logic [3:0]  done_store_id_o,
  input wire logic        last_o
);

  // A request reply always answers a load or store taken in the cycle before.
  a_reply_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o == KIND_REPLY |->
      $past(start && !busy) && ($past(op_i) == OP_LOAD || $past(op_i) == OP_STORE))
    else $error("reply without a preceding request");

  a_reply_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o == KIND_REPLY |-> last_o)
    else $error("reply not marked last");

  // The results of one tick come in consecutive cycles and hold the block busy.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy ##1 strobe_o)
    else $error("gap inside a group of results");

  a_store_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o == KIND_DONE |->
      !ok_o && bcast_rob_id_o == 5'd0 && load_value_o == 32'd0)
    else $error("store completion carries load fields");

endmodule

bind latency_slot_load_store_memory lslsm_props u_lslsm_props (.*);
`default_nettype wire

>>> sim/lslsm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lslsm_checker
// Watches the item and result channels of the load/store memory, keeps its
// own image of the memory and the slots, and compares every result with the
// oldest one it predicted. The failure count and the number of outstanding
// results go back to the testbench top.
// ----------------------------------------------------------------------------
module lslsm_checker
  import lslsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [2:0]  size_i,
  input  wire logic [4:0]  rob_id_i,
  input  wire logic [3:0]  store_id_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic        bus_free_i,
  input  wire logic        strobe_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic        ok_i,
  input  wire logic [4:0]  bcast_rob_id_i,
  input  wire logic [31:0] load_value_i,
  input  wire logic [3:0]  done_store_id_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [4:0]  rob_id;
    logic [31:0] value;
    logic [3:0]  store_id;
    logic        last;
  } mem_result_t;

  mem_result_t          expected_results[$];
  mem_result_t          oldest;
  int                   mismatches;

  logic [7:0]           mem_image [0:(1 << ADDR_BITS) - 1];
  logic [SLOTS-1:0]     load_busy;
  logic [CNT_W-1:0]     load_count [SLOTS];
  logic [ADDR_BITS-1:0] load_addr  [SLOTS];
  logic [2:0]           load_size  [SLOTS];
  logic [4:0]           load_rob   [SLOTS];
  logic [SLOTS-1:0]     store_busy;
  logic [CNT_W-1:0]     store_count [SLOTS];
  logic [3:0]           store_tag   [SLOTS];

  function automatic mem_result_t make_result(input kind_e kind, input logic ok,
                                              input logic [4:0] rob,
                                              input logic [31:0] value,
                                              input logic [3:0] sid);
    mem_result_t r;
    r          = '0;
    r.kind     = kind;
    r.ok       = ok;
    r.rob_id   = rob;
    r.value    = value;
    r.store_id = sid;
    return r;
  endfunction

  function automatic logic [31:0] sized_read(input logic [ADDR_BITS-1:0] a,
                                             input logic [2:0] code);
    logic [ADDR_BITS-1:0] a1;
    logic [ADDR_BITS-1:0] a2;
    logic [ADDR_BITS-1:0] a3;
    logic [31:0]          word;
    logic [31:0]          v;
    a1   = a + 1'b1;
    a2   = a + 2'd2;
    a3   = a + 2'd3;
    word = {mem_image[a3], mem_image[a2], mem_image[a1], mem_image[a]};
    case (code)
      SZ_BYTE_S: v = {{24{word[7]}}, word[7:0]};
      SZ_BYTE_U: v = {24'd0, word[7:0]};
      SZ_HALF_S: v = {{16{word[15]}}, word[15:0]};
      SZ_HALF_U: v = {16'd0, word[15:0]};
      SZ_WORD:   v = word;
      default:   v = '0;
    endcase
    return v;
  endfunction

  task automatic predict_results(input logic [1:0] op, input logic [15:0] addr,
                                 input logic [2:0] size, input logic [4:0] rob,
                                 input logic [3:0] sid, input logic [7:0] wbyte,
                                 input logic bus_ok);
    mem_result_t res [SLOTS+1];
    int          n;
    int          slot;
    logic        sent;
    n    = 0;
    slot = -1;
    sent = 1'b0;
    case (op)
      OP_LOAD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !load_busy[i]) slot = i;
        end
        if (slot >= 0) begin
          load_busy[slot]  = 1'b1;
          load_count[slot] = CNT_W'(SLOTS - 1);
          load_addr[slot]  = addr[ADDR_BITS-1:0];
          load_size[slot]  = size;
          load_rob[slot]   = rob;
        end
        res[n] = make_result(KIND_REPLY, slot >= 0, '0, '0, '0);
        n++;
      end
      OP_STORE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !store_busy[i]) slot = i;
        end
        if (slot >= 0) begin
          store_busy[slot]  = 1'b1;
          store_count[slot] = CNT_W'(SLOTS - 1);
          store_tag[slot]   = sid;
        end
        res[n] = make_result(KIND_REPLY, slot >= 0, '0, '0, '0);
        n++;
      end
      OP_WRITE: begin
        mem_image[addr[ADDR_BITS-1:0]] = wbyte;
      end
      default: begin
        // Only the lowest load at zero may send; if the bus is taken it waits.
        for (int i = 0; i < SLOTS; i++) begin
          if (load_busy[i]) begin
            if (load_count[i] != 0) load_count[i] = load_count[i] - 1'b1;
            if (!sent && load_count[i] == 0) begin
              sent = 1'b1;
              if (bus_ok) begin
                res[n] = make_result(KIND_BCAST, 1'b0, load_rob[i],
                                     sized_read(load_addr[i], load_size[i]), '0);
                n++;
                load_busy[i] = 1'b0;
              end
            end
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (store_busy[i]) begin
            store_count[i] = store_count[i] - 1'b1;
            if (store_count[i] == 0) begin
              store_busy[i] = 1'b0;
              res[n] = make_result(KIND_DONE, 1'b0, '0, '0, store_tag[i]);
              n++;
            end
          end
        end
      end
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < (1 << ADDR_BITS); a++) mem_image[a] = '0;
      for (int i = 0; i < SLOTS; i++) begin
        load_count[i]  = '0;
        load_addr[i]   = '0;
        load_size[i]   = '0;
        load_rob[i]    = '0;
        store_count[i] = '0;
        store_tag[i]   = '0;
      end
      load_busy  = '0;
      store_busy = '0;
      mismatches = 0;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (strobe_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual kind %0d ok %0d rob %0d value 0x%0h sid %0d",
                   $time, kind_i, ok_i, bcast_rob_id_i, load_value_i, done_store_id_i);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("kind", 32'(oldest.kind), 32'(kind_i));
          compare_field("ok", 32'(oldest.ok), 32'(ok_i));
          compare_field("bcast_rob_id", 32'(oldest.rob_id), 32'(bcast_rob_id_i));
          compare_field("load_value", oldest.value, load_value_i);
          compare_field("done_store_id", 32'(oldest.store_id), 32'(done_store_id_i));
          compare_field("last", 32'(oldest.last), 32'(last_i));
        end
      end
      if (start_i && !busy_i) begin
        predict_results(op_i, addr_i, size_i, rob_id_i, store_id_i, write_byte_i,
                        bus_free_i);
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the load/store memory with a directed opening (slot exhaustion,
// refused requests, bus stalls, sign and zero extension, address wrap, a
// tick with a broadcast and store completions) and then random bursts of
// items, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import lslsm_pkg::*;

  localparam int RANDOM_ITEMS = 444;
  localparam int DRAIN_CYCLES = 20;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [1:0]  op_i         = OP_TICK;
  logic [15:0] addr_i       = '0;
  logic [2:0]  size_i       = '0;
  logic [4:0]  rob_id_i     = '0;
  logic [3:0]  store_id_i   = '0;
  logic [7:0]  write_byte_i = '0;
  logic        bus_free_i   = 1'b0;
  logic        strobe_o;
  logic [1:0]  kind_o;
  logic        ok_o;
  logic [4:0]  bcast_rob_id_o;
  logic [31:0] load_value_o;
  logic [3:0]  done_store_id_o;
  logic        last_o;
  int          fail_count;
  int          pending;

  latency_slot_load_store_memory DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .addr_i          (addr_i),
    .size_i          (size_i),
    .rob_id_i        (rob_id_i),
    .store_id_i      (store_id_i),
    .write_byte_i    (write_byte_i),
    .bus_free_i      (bus_free_i),
    .strobe_o        (strobe_o),
    .kind_o          (kind_o),
    .ok_o            (ok_o),
    .bcast_rob_id_o  (bcast_rob_id_o),
    .load_value_o    (load_value_o),
    .done_store_id_o (done_store_id_o),
    .last_o          (last_o)
  );

  lslsm_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (op_i),
    .addr_i          (addr_i),
    .size_i          (size_i),
    .rob_id_i        (rob_id_i),
    .store_id_i      (store_id_i),
    .write_byte_i    (write_byte_i),
    .bus_free_i      (bus_free_i),
    .strobe_i        (strobe_o),
    .kind_i          (kind_o),
    .ok_i            (ok_o),
    .bcast_rob_id_i  (bcast_rob_id_o),
    .load_value_i    (load_value_o),
    .done_store_id_i (done_store_id_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(input op_e op, input logic [15:0] addr, input logic [2:0] size,
                           input logic [4:0] rob, input logic [3:0] sid,
                           input logic [7:0] wbyte, input logic bus_ok);
    start        <= 1'b1;
    op_i         <= op;
    addr_i       <= addr;
    size_i       <= size;
    rob_id_i     <= rob;
    store_id_i   <= sid;
    write_byte_i <= wbyte;
    bus_free_i   <= bus_ok;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int          burst_left;
    int          gap;
    int          pick;
    op_e         op;
    logic [15:0] addr;
    logic [2:0]  size;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_WRITE, 16'hFFFF, SZ_BYTE_S, 5'd0,  4'd0,  8'h80, 1'b0);
    send_item(OP_WRITE, 16'h0000, SZ_BYTE_S, 5'd0,  4'd0,  8'hFF, 1'b0);
    send_item(OP_WRITE, 16'h0001, SZ_BYTE_S, 5'd0,  4'd0,  8'h7F, 1'b0);
    send_item(OP_WRITE, 16'h0002, SZ_BYTE_S, 5'd0,  4'd0,  8'hA5, 1'b0);
    send_item(OP_LOAD,  16'hFFFF, SZ_BYTE_S, 5'd31, 4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'hFFFF, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'h0000, SZ_HALF_S, 5'd1,  4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'hFFFF, SZ_HALF_U, 5'd2,  4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'h0000, 3'd7,      5'd5,  4'd0,  8'h00, 1'b1);
    send_item(OP_STORE, 16'h1234, SZ_WORD,   5'd0,  4'd15, 8'h00, 1'b1);
    send_item(OP_STORE, 16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_STORE, 16'hFFFF, SZ_WORD,   5'd0,  4'd1,  8'h00, 1'b1);
    send_item(OP_STORE, 16'h8000, SZ_WORD,   5'd0,  4'd2,  8'h00, 1'b1);
    send_item(OP_STORE, 16'h0001, SZ_WORD,   5'd0,  4'd9,  8'h00, 1'b1);
    // The third tick sends the first load and completes all four stores.
    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b0);
    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b0);
    send_item(OP_TICK,  16'h0000, SZ_WORD,   5'd0,  4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'h0001, 3'd6,      5'd7,  4'd0,  8'h00, 1'b1);
    send_item(OP_LOAD,  16'hFFFF, SZ_BYTE_U, 5'd9,  4'd0,  8'h00, 1'b1);
    repeat (4) send_item(OP_TICK, 16'h0000, SZ_WORD, 5'd0, 4'd0, 8'h00, 1'b1);

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_until_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;

      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_TICK;
      else if (pick < 60) op = OP_LOAD;
      else if (pick < 78) op = OP_STORE;
      else                op = OP_WRITE;

      // Most addresses fall in two small windows, one just below the top wrap.
      pick = $urandom_range(0, 9);
      if (pick < 6)      addr = 16'($urandom_range(0, 15));
      else if (pick < 8) addr = 16'hFFF0 + 16'($urandom_range(0, 15));
      else               addr = 16'($urandom);

      size = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));

      send_item(op, addr, size, 5'($urandom), 4'($urandom), 8'($urandom),
                $urandom_range(0, 3) != 0);
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lslsm_pkg.sv
sv/lslsm_ram.sv
sv/lslsm_slots.sv
sv/latency_slot_load_store_memory.sv
sv/lslsm_checker.sv
sim/lslsm_checker.sv
sim/testbench.sv
